// ===== design/dotted_ipv4_text_parser_assert.svh =====
// ----------------------------------------------------------------------------
// Dotted IPv4 text parser assertion macros
// Concurrent checks sampled on clk and disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef DOTTED_IPV4_TEXT_PARSER_ASSERT_SVH
`define DOTTED_IPV4_TEXT_PARSER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define DIPV4_ASSERT_SAME(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("dotted_ipv4_text_parser: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define DIPV4_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("dotted_ipv4_text_parser: next-cycle check failed");

`endif

// ===== design/dipv4_pkg.sv =====
// ----------------------------------------------------------------------------
// Dotted IPv4 text parser package
// Shared types, character codes and range limits for the parser.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package dipv4_pkg;

	typedef enum logic [2:0] {
		PH_START,
		PH_ZERO,
		PH_DIGITS,
		PH_DONE,
		PH_ERROR
	} phase_t;

	typedef enum logic [1:0] {
		RX_DEC,
		RX_OCT,
		RX_HEX
	} radix_t;

	typedef struct packed {
		phase_t           phase;
		radix_t           radix;
		logic [31:0]      acc;
		logic [2:0][31:0] parts;
		logic [1:0]       count;
	} parse_state_t;

	localparam parse_state_t STATE_RESET = '{
		phase: PH_START,
		radix: RX_DEC,
		acc:   32'd0,
		parts: '0,
		count: 2'd0
	};

	localparam logic [7:0] CH_NUL  = 8'h00;
	localparam logic [7:0] CH_TAB  = 8'h09;
	localparam logic [7:0] CH_NL   = 8'h0A;
	localparam logic [7:0] CH_CR   = 8'h0D;
	localparam logic [7:0] CH_SP   = 8'h20;
	localparam logic [7:0] CH_DOT  = 8'h2E;
	localparam logic [7:0] CH_0    = 8'h30;
	localparam logic [7:0] CH_9    = 8'h39;
	localparam logic [7:0] CH_UA   = 8'h41;
	localparam logic [7:0] CH_UF   = 8'h46;
	localparam logic [7:0] CH_UX   = 8'h58;
	localparam logic [7:0] CH_LA   = 8'h61;
	localparam logic [7:0] CH_LF   = 8'h66;
	localparam logic [7:0] CH_LX   = 8'h78;
	localparam logic [7:0] CH_CASE = 8'h20;
	localparam logic [7:0] HEX_TEN = 8'd10;

	localparam logic [1:0] MAX_DOTS = 2'd3;

	localparam logic [31:0] LIMIT_8  = 32'h0000_00FF;
	localparam logic [31:0] LIMIT_16 = 32'h0000_FFFF;
	localparam logic [31:0] LIMIT_24 = 32'h00FF_FFFF;

endpackage

// ===== design/dipv4_step.sv =====
// ----------------------------------------------------------------------------
// Dotted IPv4 text parser character step
// Applies one character to the parse state and returns the next state.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dipv4_step import dipv4_pkg::*; (
	input  logic [7:0]   char_code,
	input  parse_state_t cur,
	output parse_state_t nxt
);

	parse_state_t zero_st;

	function automatic parse_state_t digit_char(parse_state_t s, logic [7:0] c);
		parse_state_t r;
		logic [7:0]   cl;
		logic [31:0]  scaled;
		r = s;
		cl = (c inside {[CH_UA:CH_UF]}) ? 8'(c + CH_CASE) : c;
		case (s.radix)
			RX_HEX: scaled = {s.acc[27:0], 4'b0000};
			RX_OCT: scaled = {s.acc[28:0], 3'b000};
			default: scaled = {s.acc[28:0], 3'b000} + {s.acc[30:0], 1'b0};
		endcase
		if (cl inside {[CH_0:CH_9]}) begin
			r.acc = scaled + {24'd0, 8'(cl - CH_0)};
		end else if ((s.radix == RX_HEX) && (cl inside {[CH_LA:CH_LF]})) begin
			r.acc = {s.acc[27:0], 4'b0000} | {24'd0, 8'(cl - CH_LA + HEX_TEN)};
		end else if (cl == CH_DOT) begin
			if (s.count == MAX_DOTS) begin
				r.phase = PH_ERROR;
			end else begin
				for (int i = 0; i < 3; i++) begin
					if (s.count == 2'(i)) begin
						r.parts[i] = s.acc;
					end
				end
				r.count = s.count + 2'd1;
				r.acc = 32'd0;
				r.radix = RX_DEC;
				r.phase = PH_START;
			end
		end else if (cl inside {CH_NUL, CH_SP, CH_TAB, CH_NL, CH_CR}) begin
			r.phase = PH_DONE;
		end else begin
			r.phase = PH_ERROR;
		end
		return r;
	endfunction

	always_comb begin
		zero_st = cur;
		zero_st.acc = 32'd0;
		zero_st.phase = PH_DIGITS;
		zero_st.radix = (char_code == CH_LX || char_code == CH_UX) ? RX_HEX : RX_OCT;
	end

	always_comb begin
		nxt = cur;
		case (cur.phase)
			PH_START: begin
				if (!(char_code inside {[CH_0:CH_9]})) begin
					nxt.phase = PH_ERROR;
				end else if (char_code == CH_0) begin
					nxt.acc = 32'd0;
					nxt.phase = PH_ZERO;
				end else begin
					nxt.radix = RX_DEC;
					nxt.acc = {24'd0, 8'(char_code - CH_0)};
					nxt.phase = PH_DIGITS;
				end
			end
			PH_ZERO: begin
				if (zero_st.radix == RX_HEX) begin
					nxt = zero_st;
				end else begin
					nxt = digit_char(zero_st, char_code);
				end
			end
			PH_DIGITS: begin
				nxt = digit_char(cur, char_code);
			end
			default: begin
				nxt = cur;
			end
		endcase
	end

endmodule

// ===== design/dipv4_pack.sv =====
// ----------------------------------------------------------------------------
// Dotted IPv4 text parser result packer
// Checks part ranges for the address form and assembles the 32-bit address.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dipv4_pack import dipv4_pkg::*; (
	input  parse_state_t fin,
	output logic         valid_res,
	output logic [31:0]  address
);

	logic        ended;
	logic        p0_ok;
	logic        p1_ok;
	logic        p2_ok;
	logic        fit;
	logic [31:0] merged;

	// The end of the string acts as a terminator for a part still in progress.
	assign ended = (fin.phase == PH_DONE) || (fin.phase == PH_ZERO) ||
		(fin.phase == PH_DIGITS);

	assign p0_ok = (fin.parts[0] <= LIMIT_8);
	assign p1_ok = (fin.parts[1] <= LIMIT_8);
	assign p2_ok = (fin.parts[2] <= LIMIT_8);

	always_comb begin
		case (fin.count)
			2'd0: begin
				fit = 1'b1;
				merged = fin.acc;
			end
			2'd1: begin
				fit = p0_ok && (fin.acc <= LIMIT_24);
				merged = fin.acc | {fin.parts[0][7:0], 24'd0};
			end
			2'd2: begin
				fit = p0_ok && p1_ok && (fin.acc <= LIMIT_16);
				merged = fin.acc | {fin.parts[0][7:0], fin.parts[1][7:0], 16'd0};
			end
			default: begin
				fit = p0_ok && p1_ok && p2_ok && (fin.acc <= LIMIT_8);
				merged = fin.acc |
					{fin.parts[0][7:0], fin.parts[1][7:0], fin.parts[2][7:0], 8'd0};
			end
		endcase
	end

	assign valid_res = ended && fit;
	assign address = valid_res ? merged : 32'd0;

endmodule

// ===== design/dotted_ipv4_text_parser.sv =====
// ----------------------------------------------------------------------------
// Dotted IPv4 text parser
// Parses an IPv4 address in dotted text, one character per request.
// ----------------------------------------------------------------------------
// Channel  Direction  Handshake            Payload
// in       input      in_valid / in_ready  char_code, last_char
// out      output     out_valid/out_ready  valid_res, address
//
// One character is taken per cycle unless a held result stalls a final character;
// its result is offered from the result register behind the input register.
// Reset returns the parse state to the start of an address and empties both
// registers. A held result stalls only a final character; other characters
// keep flowing while the result waits.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "dotted_ipv4_text_parser_assert.svh"

module dotted_ipv4_text_parser import dipv4_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  char_code,
	input  logic        last_char,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        valid_res,
	output logic [31:0] address
);

	logic         valid_s1;
	logic [7:0]   char_s1;
	logic         last_s1;
	parse_state_t state_q;
	parse_state_t next_st;
	logic         out_valid_q;
	logic         valid_res_q;
	logic [31:0]  address_q;
	logic         out_free;
	logic         fire_s1;
	logic         res_valid;
	logic [31:0]  res_address;

	dipv4_step u_step (
		.char_code (char_s1),
		.cur       (state_q),
		.nxt       (next_st)
	);

	dipv4_pack u_pack (
		.fin       (next_st),
		.valid_res (res_valid),
		.address   (res_address)
	);

	assign out_free = !out_valid_q || out_ready;
	assign fire_s1 = valid_s1 && (!last_s1 || out_free);
	assign in_ready = !valid_s1 || fire_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			char_s1 <= char_code;
			last_s1 <= last_char;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= STATE_RESET;
		end else if (fire_s1) begin
			state_q <= last_s1 ? STATE_RESET : next_st;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire_s1 && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire_s1 && last_s1) begin
			valid_res_q <= res_valid;
			address_q <= res_address;
		end
	end

	assign out_valid = out_valid_q;
	assign valid_res = valid_res_q;
	assign address = address_q;

	`DIPV4_ASSERT_SAME(a_invalid_zero, out_valid_q && !valid_res_q, address_q == 32'd0)
	`DIPV4_ASSERT_NEXT(a_last_gives_result, fire_s1 && last_s1, out_valid_q)
	`DIPV4_ASSERT_NEXT(a_state_cleared, fire_s1 && last_s1, state_q == STATE_RESET)
	`DIPV4_ASSERT_NEXT(a_stage_holds, valid_s1 && !fire_s1, valid_s1 && $stable(char_s1))

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Dotted IPv4 text parser testbench
// Feeds address strings one character per request, first a table of fixed
// strings and then random well-formed, broken and noise strings. A local
// parser model predicts results not in the table; results compare in order.
// ----------------------------------------------------------------------------

module tb_top;
	import dipv4_pkg::*;

	localparam int N_DIRECTED    = 26;
	localparam int RANDOM_ITEMS  = 830;
	localparam int PRESSURE_AT   = 40;
	localparam int PRESSURE_HOLD = 400;
	localparam int IDLE_LIMIT    = 4000;
	localparam int DRAIN_CYCLES  = 8;

	typedef struct {
		logic        ok;
		logic [31:0] addr;
	} addr_result_t;

	typedef struct {
		string       text;
		bit          has_term;
		logic [7:0]  term;
		string       tail;
		bit          known;
		logic        exp_ok;
		logic [31:0] exp_addr;
	} directed_row_t;

	logic        clk;
	logic        arst_n    = 1'b0;
	logic        in_valid  = 1'b0;
	logic        in_ready;
	logic [7:0]  char_code = 8'd0;
	logic        last_char = 1'b0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic        valid_res;
	logic [31:0] address;

	addr_result_t pending_results[$];
	logic [7:0]   text_q[$];
	int           errors        = 0;
	int           idle_cycles   = 0;
	int           send_calm     = 0;
	int           recv_calm     = 0;
	int           results_taken = 0;

	phase_t      prs_phase;
	radix_t      prs_radix;
	logic [31:0] prs_acc;
	logic [31:0] prs_parts [3];
	logic [1:0]  prs_dots;

	logic [7:0] term_codes [5] = '{CH_NUL, CH_SP, CH_TAB, CH_NL, CH_CR};

	directed_row_t directed_rows [N_DIRECTED] = '{
		'{"0",                 1'b0, CH_NUL, "",     1'b1, 1'b1, 32'h0000_0000},
		'{"4294967295",        1'b0, CH_NUL, "",     1'b1, 1'b1, 32'hFFFF_FFFF},
		'{"255.255.255.255",   1'b0, CH_NUL, "",     1'b1, 1'b1, 32'hFFFF_FFFF},
		'{"0x7F.1",            1'b0, CH_NUL, "",     1'b1, 1'b1, 32'h7F00_0001},
		'{"0Xab.0xCD.0xFFFF",  1'b0, CH_NUL, "",     1'b1, 1'b1, 32'hABCD_FFFF},
		'{"010.0.0.1",         1'b0, CH_NUL, "",     1'b1, 1'b1, 32'h0800_0001},
		'{"019",               1'b0, CH_NUL, "",     1'b1, 1'b1, 32'h0000_0011},
		'{"0x",                1'b1, CH_NL,  "",     1'b1, 1'b1, 32'h0000_0000},
		'{"4294967296",        1'b0, CH_NUL, "",     1'b1, 1'b1, 32'h0000_0000},
		'{"1.2.3.4.5",         1'b0, CH_NUL, "",     1'b1, 1'b0, 32'h0000_0000},
		'{"a.1",               1'b0, CH_NUL, "",     1'b1, 1'b0, 32'h0000_0000},
		'{"1..2",              1'b0, CH_NUL, "",     1'b1, 1'b0, 32'h0000_0000},
		'{"1.",                1'b0, CH_NUL, "",     1'b1, 1'b0, 32'h0000_0000},
		'{"1.2.3.256",         1'b0, CH_NUL, "",     1'b1, 1'b0, 32'h0000_0000},
		'{"256.1",             1'b0, CH_NUL, "",     1'b1, 1'b0, 32'h0000_0000},
		'{"1.16777216",        1'b0, CH_NUL, "",     1'b1, 1'b0, 32'h0000_0000},
		'{"1.16777215",        1'b0, CH_NUL, "",     1'b1, 1'b1, 32'h01FF_FFFF},
		'{"1.2.65535",         1'b0, CH_NUL, "",     1'b1, 1'b1, 32'h0102_FFFF},
		'{"0xg",               1'b0, CH_NUL, "",     1'b1, 1'b0, 32'h0000_0000},
		'{"1.2.3.4",           1'b1, CH_SP,  "junk", 1'b1, 1'b1, 32'h0102_0304},
		'{"10.0.0.1",          1'b1, CH_NUL, "9.9",  1'b1, 1'b1, 32'h0A00_0001},
		'{"",                  1'b1, CH_NUL, "",     1'b1, 1'b0, 32'h0000_0000},
		'{"8.8.8.8",           1'b1, CH_TAB, ".1",   1'b1, 1'b1, 32'h0808_0808},
		'{"1.2.3.4",           1'b1, 8'hFF,  "",     1'b1, 1'b0, 32'h0000_0000},
		'{"0377.0x10.0177777", 1'b1, CH_CR,  "",     1'b0, 1'b0, 32'h0000_0000},
		'{"07777777777777.1",  1'b0, CH_NUL, "",     1'b0, 1'b0, 32'h0000_0000}
	};

	dotted_ipv4_text_parser u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.char_code (char_code),
		.last_char (last_char),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.valid_res (valid_res),
		.address   (address)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic int draw_gap(inout int calm);
		if (calm > 0) begin
			calm--;
			return 0;
		end
		if ($urandom_range(0, 15) == 0) begin
			calm = $urandom_range(10, 30);
			return 0;
		end
		return $urandom_range(0, 17);
	endfunction

	function automatic bit is_terminator(logic [7:0] ch);
		return ch == CH_NUL || ch == CH_SP || ch == CH_TAB || ch == CH_NL || ch == CH_CR;
	endfunction

	function automatic void clear_parser();
		prs_phase    = PH_START;
		prs_radix    = RX_DEC;
		prs_acc      = 32'd0;
		prs_parts[0] = 32'd0;
		prs_parts[1] = 32'd0;
		prs_parts[2] = 32'd0;
		prs_dots     = 2'd0;
	endfunction

	function automatic void take_digit(logic [7:0] ch);
		logic [7:0]  c;
		logic [31:0] base;
		c    = ch;
		base = (prs_radix == RX_HEX) ? 32'd16 : ((prs_radix == RX_OCT) ? 32'd8 : 32'd10);
		if (c >= CH_UA && c <= CH_UF)
			c = c + CH_CASE;
		if (c >= CH_0 && c <= CH_9) begin
			prs_acc = prs_acc * base + {24'd0, (c - CH_0)};
		end else if (prs_radix == RX_HEX && c >= CH_LA && c <= CH_LF) begin
			prs_acc = (prs_acc << 4) | {24'd0, (c - CH_LA + HEX_TEN)};
		end else if (c == CH_DOT) begin
			if (prs_dots >= MAX_DOTS) begin
				prs_phase = PH_ERROR;
			end else begin
				prs_parts[prs_dots] = prs_acc;
				prs_dots  = prs_dots + 2'd1;
				prs_acc   = 32'd0;
				prs_radix = RX_DEC;
				prs_phase = PH_START;
			end
		end else if (is_terminator(c)) begin
			prs_phase = PH_DONE;
		end else begin
			prs_phase = PH_ERROR;
		end
	endfunction

	function automatic void feed_char(logic [7:0] ch);
		case (prs_phase)
			PH_START: begin
				if (!(ch >= CH_0 && ch <= CH_9)) begin
					prs_phase = PH_ERROR;
				end else if (ch == CH_0) begin
					prs_acc   = 32'd0;
					prs_phase = PH_ZERO;
				end else begin
					prs_radix = RX_DEC;
					prs_acc   = {24'd0, (ch - CH_0)};
					prs_phase = PH_DIGITS;
				end
			end
			PH_ZERO: begin
				prs_acc = 32'd0;
				if (ch == CH_LX || ch == CH_UX) begin
					prs_radix = RX_HEX;
					prs_phase = PH_DIGITS;
				end else begin
					prs_radix = RX_OCT;
					prs_phase = PH_DIGITS;
					take_digit(ch);
				end
			end
			PH_DIGITS: begin
				take_digit(ch);
			end
			default: begin
			end
		endcase
	endfunction

	function automatic void parse_char(input logic [7:0] ch, input bit last,
			output bit got, output addr_result_t res);
		logic [31:0] p0;
		logic [31:0] p1;
		logic [31:0] p2;
		logic [31:0] v;
		logic        ok;
		p0  = prs_parts[0];
		p1  = prs_parts[1];
		p2  = prs_parts[2];
		got = 1'b0;
		res = '{1'b0, 32'd0};
		feed_char(ch);
		if (last) begin
			if (prs_phase == PH_START || prs_phase == PH_ZERO || prs_phase == PH_DIGITS)
				feed_char(CH_NUL);
			ok = (prs_phase == PH_DONE);
			v  = prs_acc;
			if (ok) begin
				case (prs_dots)
					2'd0: begin
					end
					2'd1: begin
						if (p0 > LIMIT_8 || v > LIMIT_24)
							ok = 1'b0;
						else
							v = v | (p0 << 24);
					end
					2'd2: begin
						if (p0 > LIMIT_8 || p1 > LIMIT_8 || v > LIMIT_16)
							ok = 1'b0;
						else
							v = v | (p0 << 24) | (p1 << 16);
					end
					default: begin
						if (p0 > LIMIT_8 || p1 > LIMIT_8 || p2 > LIMIT_8 || v > LIMIT_8)
							ok = 1'b0;
						else
							v = v | (p0 << 24) | (p1 << 16) | (p2 << 8);
					end
				endcase
			end
			res.ok   = ok;
			res.addr = ok ? v : 32'd0;
			got      = 1'b1;
			clear_parser();
		end
	endfunction

	function automatic void append_string(string s);
		int i;
		for (i = 0; i < s.len(); i++)
			text_q.push_back(s[i]);
	endfunction

	function automatic string gen_part(logic [31:0] lim);
		logic [31:0] v;
		string       s;
		int          len;
		int          i;
		case ($urandom_range(0, 9))
			7: v = lim + $urandom_range(1, 3);
			8: v = $urandom;
			9: begin
				s   = "";
				len = $urandom_range(1, 12);
				for (i = 0; i < len; i++)
					s = $sformatf("%s%0d", s, $urandom_range(0, 9));
				return s;
			end
			default: v = (lim == 32'hFFFF_FFFF) ? $urandom : $urandom_range(lim, 0);
		endcase
		case ($urandom_range(0, 2))
			0: s = $sformatf("%0d", v);
			1: s = $sformatf("0%0o", v);
			default: begin
				s = $sformatf("%0h", v);
				for (i = 0; i < s.len(); i++)
					if (s[i] >= CH_LA && s[i] <= CH_LF && $urandom_range(0, 1) == 1)
						s[i] = s[i] - CH_CASE;
				s = {($urandom_range(0, 1) == 1) ? "0X" : "0x", s};
			end
		endcase
		return s;
	endfunction

	function automatic void gen_random_text();
		int          n;
		int          i;
		int          len;
		logic [31:0] lim;
		text_q.delete();
		if ($urandom_range(0, 9) == 0) begin
			len = $urandom_range(1, 6);
			for (i = 0; i < len; i++)
				text_q.push_back(8'($urandom_range(0, 255)));
			return;
		end
		n = $urandom_range(1, 4);
		for (i = 0; i < n; i++) begin
			if (i > 0)
				text_q.push_back(CH_DOT);
			if (i < n - 1)
				lim = LIMIT_8;
			else
				lim = (n == 1) ? 32'hFFFF_FFFF : (n == 2) ? LIMIT_24 :
					(n == 3) ? LIMIT_16 : LIMIT_8;
			append_string(gen_part(lim));
		end
		if ($urandom_range(0, 5) == 0) begin
			i = $urandom_range(0, text_q.size() - 1);
			case ($urandom_range(0, 2))
				0: text_q[i] = CH_DOT;
				1: text_q[i] = CH_LX;
				default: text_q[i] = 8'($urandom_range(0, 255));
			endcase
		end
		if ($urandom_range(0, 3) != 0) begin
			text_q.push_back(term_codes[$urandom_range(0, 4)]);
			len = $urandom_range(0, 4);
			for (i = 0; i < len; i++)
				text_q.push_back(8'($urandom_range(0, 255)));
		end
	endfunction

	task automatic send_text(input bit known, input logic exp_ok, input logic [31:0] exp_addr);
		int           i;
		int           gap;
		bit           got;
		bit           last;
		addr_result_t res;
		for (i = 0; i < text_q.size(); i++) begin
			last = (i == text_q.size() - 1);
			gap  = draw_gap(send_calm);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			in_valid  <= 1'b1;
			char_code <= text_q[i];
			last_char <= last;
			do @(posedge clk); while (!in_ready);
			parse_char(text_q[i], last, got, res);
			if (got) begin
				if (known)
					res = '{exp_ok, exp_addr};
				pending_results.push_back(res);
			end
		end
	endtask

	initial begin
		int row;
		int random_items;
		clear_parser();
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		for (row = 0; row < N_DIRECTED; row++) begin
			text_q.delete();
			append_string(directed_rows[row].text);
			if (directed_rows[row].has_term)
				text_q.push_back(directed_rows[row].term);
			append_string(directed_rows[row].tail);
			send_text(directed_rows[row].known, directed_rows[row].exp_ok,
				directed_rows[row].exp_addr);
		end
		random_items = 0;
		while (random_items < RANDOM_ITEMS) begin
			gen_random_text();
			random_items += text_q.size();
			send_text(1'b0, 1'b0, 32'd0);
		end
		in_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

	initial begin
		int           gap;
		addr_result_t want;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			gap = (results_taken == PRESSURE_AT) ? PRESSURE_HOLD : draw_gap(recv_calm);
			if (gap > 0) begin
				out_ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
			results_taken++;
			if (pending_results.size() == 0) begin
				$display("%0t: result with nothing pending, actual valid_res %0b address %h",
					$time, valid_res, address);
				errors++;
			end else begin
				want = pending_results.pop_front();
				if (valid_res !== want.ok) begin
					$display("%0t: valid_res mismatch, expected %0b, actual %0b",
						$time, want.ok, valid_res);
					errors++;
				end
				if (address !== want.addr) begin
					$display("%0t: address mismatch, expected %h, actual %h",
						$time, want.addr, address);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("Regression FAIL");
				$finish;
			end
		end
	end

endmodule

// ===== sim.f =====
+incdir+design
design/dipv4_pkg.sv
design/dipv4_step.sv
design/dipv4_pack.sv
design/dotted_ipv4_text_parser.sv
tb/tb_top.sv
